// ===== rtl/vrd_pkg.sv =====
// vrd_pkg: constants, types and helpers for the vector_rotate_by_degrees pipeline.
// No dependencies.
package vrd_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int STEPS        = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  localparam int GUARD_BITS = 24;
  localparam int XW         = 58;   // coordinate with guard bits and growth
  localparam int ZW         = 34;   // residual angle
  localparam int RW         = XW - GUARD_BITS;

  typedef logic signed [XW-1:0] coord_t;
  typedef logic signed [ZW-1:0] zang_t;

  typedef struct packed {
    logic        clip;
    logic [31:0] value;
  } sat_t;

  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

  // angle reduction: turn = 45 * 2^19 in Q16.16 degrees
  localparam logic [13:0] QOFS        = 14'd4140;     // 92 * 45
  localparam logic [13:0] RECIP45_Q19 = 14'd11651;
  localparam logic [21:0] RECIP45_Q27 = 22'd2982617;
  localparam logic [26:0] TURN_HI     = 27'd95443717; // floor(2^32 / 45)
  localparam logic [7:0]  TURN_LO     = 8'd182;       // floor(2^13 / 45)
  localparam logic [4:0]  TURN_REM    = 5'd31;        // 2^32 mod 45
  localparam logic [5:0]  MOD45       = 6'd45;
  localparam logic [4:0]  HALF45      = 5'd22;

  localparam logic signed [31:0] QTR_POS = 32'sd1073741824;
  localparam logic signed [31:0] QTR_NEG = -32'sd1073741824;
  localparam zang_t Z_QTR_POS = zang_t'(64'sd1073741824);
  localparam zang_t Z_QTR_NEG = zang_t'(-64'sd1073741824);

  localparam coord_t RND_HALF = coord_t'(64'd1 << (GUARD_BITS - 1));

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
    30'd20,        30'd10,        30'd5,         30'd3,        30'd1,
    30'd1,         30'd0
  };

  function automatic sat_t round_sat(coord_t v);
    coord_t              r;
    logic signed [RW-1:0] s;
    sat_t                o;
    r = v + RND_HALF;
    s = r[XW-1:GUARD_BITS];
    if ((s[RW-1:31] == '0) || (s[RW-1:31] == '1)) begin
      o.clip  = 1'b0;
      o.value = s[31:0];
    end else begin
      o.clip  = 1'b1;
      o.value = s[RW-1] ? SAT_MIN : SAT_MAX;
    end
    return o;
  endfunction

endpackage

// ===== rtl/vector_rotate_by_degrees.sv =====
// Pipeline: registers of stages A, B, C, the CORDIC stages, then the output register.
// Throughput: one transaction per cycle if unstalled; one unrolled stage per micro-rotation.
// Stall: out_stall_i freezes the whole pipeline while a result waits at the output.
// Reset: asynchronous, active low; clears all valid bits, payload is not reset.
// Rotates a Q16.16 point clockwise by Q16.16 degrees with a gain-compensated CORDIC.
// Depends on vrd_pkg.
module vector_rotate_by_degrees (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] turn_degrees_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] rotated_x_o,
  output logic signed [31:0] rotated_y_o,
  output logic               clipped_o
);
  import vrd_pkg::*;

  logic adv;

  // stage A: gain products, coarse angle reduction
  logic signed [12:0] qs;
  logic [13:0]        qm_d;
  logic [27:0]        qt_d;
  logic signed [64:0] xp_d, yp_d;
  logic               a_vld_q;
  logic signed [64:0] a_xp_q, a_yp_q;
  logic [13:0]        a_qm_q;
  logic [27:0]        a_qt_q;
  logic [18:0]        a_l_q;

  // stage B: turn index mod 45
  logic [13:0] q45;
  logic [5:0]  h_d;
  logic        b_vld_q;
  logic [5:0]  b_h_q;
  logic [18:0] b_l_q;
  coord_t      b_x_q, b_y_q;

  // stage C: binary angle parts
  logic [20:0] w_d;
  logic [42:0] wp_d;
  logic [31:0] base_d;
  logic        c_vld_q;
  logic [42:0] c_wp_q;
  logic [31:0] c_base_q;
  coord_t      c_x_q, c_y_q;

  // stage D: fold
  logic [31:0]        bin;
  logic [31:0]        ang;
  logic               fold;
  logic [31:0]        angf;

  // CORDIC stages
  logic   cv_q [STEPS+1];
  coord_t cx_q [STEPS+1];
  coord_t cy_q [STEPS+1];
  zang_t  cz_q [STEPS+1];
  coord_t cx_d [STEPS+1];
  coord_t cy_d [STEPS+1];
  zang_t  cz_d [STEPS+1];

  // output
  sat_t        sx, sy;
  logic        out_vld_q;
  logic [31:0] rx_q, ry_q;
  logic        clip_q;

  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  assign qs   = turn_degrees_i[31:19];
  assign qm_d = 14'({qs[12], qs}) + QOFS;
  assign qt_d = 28'(qm_d) * 28'(RECIP45_Q19);
  assign xp_d = $signed(point_x_i) * $signed({1'b0, GAIN_Q32});
  assign yp_d = $signed(point_y_i) * $signed({1'b0, GAIN_Q32});

  assign q45 = 14'(a_qt_q[27:19]) * 14'(MOD45);
  assign h_d = 6'(a_qm_q - q45);

  assign w_d    = 21'(b_h_q) * 21'(TURN_REM) + {1'b0, b_l_q, 1'b0} + 21'(HALF45);
  assign wp_d   = 43'(w_d) * 43'(RECIP45_Q27);
  assign base_d = 32'(b_h_q) * 32'(TURN_HI) + 32'(b_l_q) * 32'(TURN_LO);

  assign bin  = c_base_q + 32'(c_wp_q[42:27]);
  assign ang  = 32'd0 - bin;
  assign fold = ($signed(ang) > QTR_POS) || ($signed(ang) < QTR_NEG);
  assign angf = fold ? {~ang[31], ang[30:0]} : ang;

  always_comb begin
    cx_d[0] = fold ? -c_x_q : c_x_q;
    cy_d[0] = fold ? -c_y_q : c_y_q;
    cz_d[0] = zang_t'($signed(angf));
    for (int k = 0; k < STEPS; k++) begin
      if (!cz_q[k][ZW-1]) begin
        cx_d[k+1] = cx_q[k] - (cy_q[k] >>> k);
        cy_d[k+1] = cy_q[k] + (cx_q[k] >>> k);
        cz_d[k+1] = cz_q[k] - zang_t'(ATAN_TAB[k]);
      end else begin
        cx_d[k+1] = cx_q[k] + (cy_q[k] >>> k);
        cy_d[k+1] = cy_q[k] - (cx_q[k] >>> k);
        cz_d[k+1] = cz_q[k] + zang_t'(ATAN_TAB[k]);
      end
    end
  end

  assign sx = round_sat(cx_q[STEPS]);
  assign sy = round_sat(cy_q[STEPS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k <= STEPS; k++) begin
        cv_q[k] <= 1'b0;
      end
    end else if (adv) begin
      a_vld_q   <= in_valid_i;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      cv_q[0]   <= c_vld_q;
      for (int k = 0; k < STEPS; k++) begin
        cv_q[k+1] <= cv_q[k];
      end
      out_vld_q <= cv_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_xp_q   <= xp_d;
      a_yp_q   <= yp_d;
      a_qm_q   <= qm_d;
      a_qt_q   <= qt_d;
      a_l_q    <= turn_degrees_i[18:0];
      b_h_q    <= h_d;
      b_l_q    <= a_l_q;
      b_x_q    <= {a_xp_q[64], a_xp_q[64:8]};
      b_y_q    <= {a_yp_q[64], a_yp_q[64:8]};
      c_wp_q   <= wp_d;
      c_base_q <= base_d;
      c_x_q    <= b_x_q;
      c_y_q    <= b_y_q;
      for (int k = 0; k <= STEPS; k++) begin
        cx_q[k] <= cx_d[k];
        cy_q[k] <= cy_d[k];
        cz_q[k] <= cz_d[k];
      end
      rx_q   <= sx.value;
      ry_q   <= sy.value;
      clip_q <= sx.clip | sy.clip;
    end
  end

  assign out_valid_o = out_vld_q;
  assign rotated_x_o = rx_q;
  assign rotated_y_o = ry_q;
  assign clipped_o   = clip_q;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("pipeline stalled without a waiting result");

  a_mod45_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q |-> (b_h_q < MOD45))
    else $error("turn index not reduced below 45");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_q[0] |-> ((cz_q[0] <= Z_QTR_POS) && (cz_q[0] >= Z_QTR_NEG)))
    else $error("folded angle outside a quarter turn");

  a_clip_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |-> ((rx_q == SAT_MAX) || (rx_q == SAT_MIN) ||
                                    (ry_q == SAT_MAX) || (ry_q == SAT_MIN)))
    else $error("clip flag without a saturated component");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && cv_q[STEPS]) |=> out_valid_o)
    else $error("transaction lost at output stage");
`endif

endmodule

// ===== dv/tb_vector_rotate_by_degrees.sv =====
`timescale 1ns / 100ps
// tb_vector_rotate_by_degrees: directed and random test of the CORDIC point rotator.
// Holds its own bit-exact model of the rotation and checks every transaction in order.
// Depends on vrd_pkg and vector_rotate_by_degrees.
module tb_vector_rotate_by_degrees;

  localparam int STEPS = (vrd_pkg::CORDIC_STEPS > 32) ? 32 : vrd_pkg::CORDIC_STEPS;

  localparam int ONE    = 65536;
  localparam int DEG45  = 2949120;
  localparam int DEG90  = 5898240;
  localparam int DEG180 = 11796480;
  localparam int DEG360 = 23592960;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;

  localparam longint FULL_TURN = 64'sd23592960;
  localparam longint HALF_TURN = 64'sd11796480;
  localparam longint GAIN      = 64'sd2608131496;
  localparam longint QUARTER   = 64'sd1073741824;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] turn;
  } point_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               clip;
  } rotation_t;

  typedef struct packed {
    point_t    p;
    logic      typed;
    rotation_t want;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] turn_degrees = '0;
  logic               out_stall = 1'b0;
  wire                in_stall;
  wire                out_valid;
  wire signed [31:0]  rotated_x;
  wire signed [31:0]  rotated_y;
  wire                clipped;

  rotation_t pending_rotations [$];
  int        err_cnt = 0;
  int        sent_cnt = 0;
  int        done_cnt = 0;

  longint atan_step [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  directed_row_t directed_rows [25] = '{
    '{'{32'sd0, 32'sd0, 32'sd0},      1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{'{32'sd0, 32'sd0, MAXV},        1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{'{32'sd0, 32'sd0, MINV},        1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{'{ONE, 32'sd0, 32'sd0},         1'b0, '0},
    '{'{ONE, 32'sd0, DEG90},          1'b0, '0},
    '{'{ONE, 32'sd0, -DEG90},         1'b0, '0},
    '{'{ONE, 32'sd0, DEG180},         1'b0, '0},
    '{'{ONE, 32'sd0, DEG180 + DEG90}, 1'b0, '0},
    '{'{ONE, 32'sd0, DEG360},         1'b0, '0},
    '{'{32'sd0, ONE, DEG45},          1'b0, '0},
    '{'{32'sd0, ONE, -DEG45},         1'b0, '0},
    '{'{ONE, ONE, DEG90 + 1},         1'b0, '0},
    '{'{ONE, ONE, -DEG90 - 1},        1'b0, '0},
    '{'{ONE, -ONE, MAXV},             1'b0, '0},
    '{'{-ONE, ONE, MINV},             1'b0, '0},
    '{'{MAXV, MAXV, DEG45},           1'b0, '0},
    '{'{MINV, MINV, DEG45},           1'b0, '0},
    '{'{MAXV, MINV, -DEG45},          1'b0, '0},
    '{'{MAXV, MAXV, 32'sd0},          1'b0, '0},
    '{'{MINV, MINV, 32'sd0},          1'b0, '0},
    '{'{MINV, MAXV, DEG180},          1'b0, '0},
    '{'{MAXV, 32'sd0, DEG90},         1'b0, '0},
    '{'{MINV, MINV, DEG180},          1'b0, '0},
    '{'{-32'sd1, -32'sd1, DEG360 - 1}, 1'b0, '0},
    '{'{32'sd1, 32'sd1, 1 - DEG360},  1'b0, '0}
  };

  vector_rotate_by_degrees dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .point_x_i      (point_x),
    .point_y_i      (point_y),
    .turn_degrees_i (turn_degrees),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .rotated_x_o    (rotated_x),
    .rotated_y_o    (rotated_y),
    .clipped_o      (clipped)
  );

  always #2 clk = ~clk;

  function automatic logic signed [31:0] round_to_q16(longint v, inout logic clip);
    longint r;
    r = (v + (64'sd1 <<< 23)) >>> 24;
    if (r > 64'sd2147483647) begin
      clip = 1'b1;
      return MAXV;
    end
    if (r < -64'sd2147483648) begin
      clip = 1'b1;
      return MINV;
    end
    return r[31:0];
  endfunction

  function automatic rotation_t rotate_point(point_t p);
    longint    rem, bin, x, y, z, dx, dy;
    logic [31:0] ang;
    rotation_t r;
    rem = longint'(p.turn) % FULL_TURN;
    if (rem < 0) begin
      rem += FULL_TURN;
    end
    bin = ((rem <<< 32) + HALF_TURN) / FULL_TURN;
    ang = 32'd0 - bin[31:0];
    x = (longint'(p.x) * GAIN) >>> 8;
    y = (longint'(p.y) * GAIN) >>> 8;
    z = longint'($signed(ang));
    if (z > QUARTER || z < -QUARTER) begin
      x = -x;
      y = -y;
      ang = ang + 32'h8000_0000;
      z = longint'($signed(ang));
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_step[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_step[i];
      end
    end
    r.clip = 1'b0;
    r.x = round_to_q16(x, r.clip);
    r.y = round_to_q16(y, r.clip);
    return r;
  endfunction

  function automatic point_t random_point();
    point_t p;
    int     pick;
    p.x = $signed($urandom) >>> $urandom_range(24, 0);
    p.y = $signed($urandom) >>> $urandom_range(24, 0);
    pick = $urandom_range(9);
    if (pick < 4) begin
      p.turn = $urandom;
    end else if (pick < 7) begin
      p.turn = int'($urandom_range(94371840)) - 47185920;
    end else begin
      // multiples of a quarter turn, give or take a few LSBs
      p.turn = (int'($urandom_range(16)) - 8) * DEG90 + int'($urandom_range(8)) - 4;
    end
    return p;
  endfunction

  task automatic offer(point_t p, rotation_t want);
    while ($urandom_range(99) < ((sent_cnt >= 400 && sent_cnt < 900) ? 0 : 37)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    point_x      <= p.x;
    point_y      <= p.y;
    turn_degrees <= p.turn;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_rotations.push_back(want);
    sent_cnt++;
  endtask

  initial begin : stimulus
    point_t p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].p,
            directed_rows[i].typed ? directed_rows[i].want : rotate_point(directed_rows[i].p));
    end
    repeat (1850) begin
      p = random_point();
      offer(p, rotate_point(p));
    end
    in_valid <= 1'b0;
    while (pending_rotations.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : drain
    rotation_t want;
    int        hold_left;
    bit        held;
    hold_left = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        done_cnt++;
        if (pending_rotations.size() == 0) begin
          $display("%0t: unexpected transaction x=%0d y=%0d clip=%0b",
                   $time, rotated_x, rotated_y, clipped);
          err_cnt++;
        end else begin
          want = pending_rotations.pop_front();
          if (rotated_x !== want.x) begin
            $display("%0t: rotated_x expected %0d got %0d", $time, want.x, rotated_x);
            err_cnt++;
          end
          if (rotated_y !== want.y) begin
            $display("%0t: rotated_y expected %0d got %0d", $time, want.y, rotated_y);
            err_cnt++;
          end
          if (clipped !== want.clip) begin
            $display("%0t: clipped expected %0b got %0b", $time, want.clip, clipped);
            err_cnt++;
          end
        end
      end
      // one long hold-off so the pipeline fills and backs up into the input
      if (!held && done_cnt >= 1000) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < ((done_cnt >= 300 && done_cnt < 800) ? 0 : 37));
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vrd_pkg.sv
rtl/vector_rotate_by_degrees.sv
dv/tb_vector_rotate_by_degrees.sv
